FILE: rtl/core/nfa_pkg.sv
// ---------------------------------------------------------------------------
// nfa_pkg: shared types and constants for the NFA regex matcher
// Item codes, the command passed from the front end to the engine, result
// codes, configuration register indexes and successor checks.
// ---------------------------------------------------------------------------
package nfa_pkg;

  // Item kind codes on the input channel
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CHAR  = 2'd2;

  // Configuration register indexes
  localparam logic REG_WHOLE_MATCH = 1'b0;
  localparam logic REG_STATE_COUNT = 1'b1;

  // Table encodings
  localparam logic [7:0] SPLIT_SYMBOL = 8'd45;   // '-'
  localparam logic [7:0] NUL_CHAR     = 8'd0;
  localparam logic [5:0] NO_SUCC      = 6'h3F;   // -1 in six bits
  localparam logic [5:0] COUNT_RESET  = 6'd32;

  // Command classes queued between front end and engine
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_CHAR
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  idx;
    logic [7:0]  symbol;
    logic [5:0]  next_a;
    logic [5:0]  next_b;
    logic [15:0] start_index;
    logic [7:0]  character;
  } cmd_t;

  // Result codes
  typedef enum logic [1:0] {
    OUT_MATCH   = 2'd0,
    OUT_NOMATCH = 2'd1,
    OUT_ERROR   = 2'd2
  } outcome_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic closing;   // epsilon closure in progress
    logic settle;    // closure stable this cycle
  } status_t;

  // Successor out of range: negative or at/above the active limit
  function automatic logic succ_bad(input logic [5:0] s, input logic [5:0] lim);
    return s[5] || (s >= lim);
  endfunction

endpackage

FILE: rtl/core/nfa_regex_matcher.sv
// ---------------------------------------------------------------------------
// nfa_regex_matcher: state-table NFA matcher over a character stream
// Front end classifies and queues items; the engine closes the active set
// over epsilon moves one round per cycle and consumes characters.
//
// Channel   Direction  Handshake          Carries
// input     in         push / full        kind, entry_*, start_index, character
// result    out        empty / pop        outcome, end_index
// config    in         cfg_write          cfg_index, cfg_data (no wait)
//
// Load and start items are handled straight from the idle state; a character
// runs closure rounds until the active set stops growing, and the engine
// then checks for exit and errors and consumes the character.
// A two-beat command queue sits before the engine, so input beats keep
// flowing while it works. Synchronous reset clears control state; the table
// holds no reset and must be loaded. The engine waits only when a new result
// is ready while the previous one has not been popped.
// ---------------------------------------------------------------------------
module nfa_regex_matcher #(
  parameter int NSTATES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind,
  input  logic [4:0]         entry_index,
  input  logic [7:0]         entry_symbol,
  input  logic signed [5:0]  entry_next_a,
  input  logic signed [5:0]  entry_next_b,
  input  logic [15:0]        start_index,
  input  logic [7:0]         character,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         outcome,
  output logic [15:0]        end_index,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data
);

  logic                 head_valid;
  nfa_pkg::cmd_t        head;
  logic                 take;
  logic                 res_valid;
  logic                 res_pop;
  nfa_pkg::outcome_t    res_outcome;
  nfa_pkg::status_t     status;
  logic [NSTATES-1:0]   act_set;

  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;
  assign outcome = res_outcome;

  // Front end: classify and queue
  nfa_front #(
    .NSTATES (NSTATES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .entry_index  (entry_index),
    .entry_symbol (entry_symbol),
    .entry_next_a (entry_next_a),
    .entry_next_b (entry_next_b),
    .start_index  (start_index),
    .character    (character),
    .head_valid   (head_valid),
    .head         (head),
    .take         (take)
  );

  // Engine: table, closure and result register
  nfa_back #(
    .NSTATES (NSTATES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .take        (take),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .res_valid   (res_valid),
    .res_pop     (res_pop),
    .res_outcome (res_outcome),
    .res_end     (end_index),
    .status      (status),
    .act_set     (act_set)
  );

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // A result only appears out of the closure state
  a_result_from_close: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(status.closing))
    else $error("result produced outside closure");

  // Closure rounds never drop a reached state
  a_closure_grows: assert property (@(posedge clk) disable iff (rst)
    status.closing && $past(status.closing) && !$past(status.settle)
      |-> (($past(act_set) & ~act_set) == '0))
    else $error("active set shrank during closure");

endmodule

FILE: rtl/core/nfa_front.sv
// ---------------------------------------------------------------------------
// nfa_front: input classifier and command queue
// Takes input beats, drops items that have no effect (unused kind code,
// load beyond the table) and queues the rest for the engine.
// ---------------------------------------------------------------------------
module nfa_front #(
  parameter int NSTATES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          kind,
  input  logic [4:0]          entry_index,
  input  logic [7:0]          entry_symbol,
  input  logic signed [5:0]   entry_next_a,
  input  logic signed [5:0]   entry_next_b,
  input  logic [15:0]         start_index,
  input  logic [7:0]          character,
  output logic                head_valid,
  output nfa_pkg::cmd_t       head,
  input  logic                take
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  nfa_pkg::cmd_t          q [QDEPTH];
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W-1:0]       wr_ptr;
  logic [CNT_W-1:0]       count;
  nfa_pkg::cmd_t          cmd_in;
  logic                   keep;
  logic                   enq;

  // Classify the incoming item
  always_comb begin
    cmd_in.idx         = entry_index;
    cmd_in.symbol      = entry_symbol;
    cmd_in.next_a      = $unsigned(entry_next_a);
    cmd_in.next_b      = $unsigned(entry_next_b);
    cmd_in.start_index = start_index;
    cmd_in.character   = character;
    unique case (kind)
      nfa_pkg::KIND_LOAD: begin
        cmd_in.op = nfa_pkg::OP_LOAD;
        keep      = (int'(entry_index) < NSTATES);
      end
      nfa_pkg::KIND_START: begin
        cmd_in.op = nfa_pkg::OP_START;
        keep      = 1'b1;
      end
      nfa_pkg::KIND_CHAR: begin
        cmd_in.op = nfa_pkg::OP_CHAR;
        keep      = 1'b1;
      end
      default: begin
        cmd_in.op = nfa_pkg::OP_CHAR;
        keep      = 1'b0;
      end
    endcase
  end

  assign full       = (count == CNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign enq        = push && !full && keep;

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(enq) - CNT_W'(take);
    end
  end

endmodule

FILE: rtl/core/nfa_back.sv
// ---------------------------------------------------------------------------
// nfa_back: automaton engine
// Holds the state table, configuration and active set. Runs one epsilon
// closure round per cycle, then checks for exit, errors and consumes the
// character. Results go to a one-beat output register.
// ---------------------------------------------------------------------------
module nfa_back #(
  parameter int NSTATES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  nfa_pkg::cmd_t         head,
  output logic                  take,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [5:0]            cfg_data,
  output logic                  res_valid,
  input  logic                  res_pop,
  output nfa_pkg::outcome_t     res_outcome,
  output logic [15:0]           res_end,
  output nfa_pkg::status_t      status,
  output logic [NSTATES-1:0]    act_set
);

  localparam int IDX_W   = (NSTATES > 1) ? $clog2(NSTATES) : 1;
  localparam int LIM_CAP = (NSTATES > 63) ? 63 : NSTATES;

  typedef enum logic {
    ST_IDLE,
    ST_CLOSE
  } state_t;

  state_t               state;
  logic                 in_progress;
  logic [15:0]          position;
  logic [15:0]          origin_index;
  logic                 whole_match;
  logic [5:0]           state_count;
  logic [7:0]           cur_char;

  logic [7:0]           tab_sym [NSTATES];
  logic [5:0]           tab_a   [NSTATES];
  logic [5:0]           tab_b   [NSTATES];
  logic [IDX_W-1:0]     wr_idx;

  logic [5:0]           lim;
  logic [NSTATES-1:0]   adds;
  logic [NSTATES-1:0]   step_set;
  logic                 close_err;
  logic                 step_err;
  logic                 exit_seen;
  logic                 changed;
  logic                 matched;
  logic                 any_err;
  logic                 need_res;
  logic                 slot_free;
  logic                 finishing;

  assign lim    = (state_count < 6'(LIM_CAP)) ? state_count : 6'(LIM_CAP);
  assign wr_idx = IDX_W'(head.idx);
  assign take   = (state == ST_IDLE) && head_valid;

  // Table write port; entries are undefined until loaded
  always_ff @(posedge clk) begin
    if (take && head.op == nfa_pkg::OP_LOAD) begin
      tab_sym[wr_idx] <= head.symbol;
      tab_a[wr_idx]   <= head.next_a;
      tab_b[wr_idx]   <= head.next_b;
    end
  end

  // One closure round plus the consume step, every entry in parallel
  always_comb begin
    adds      = '0;
    step_set  = '0;
    close_err = 1'b0;
    step_err  = 1'b0;
    exit_seen = 1'b0;
    for (int i = 0; i < NSTATES; i++) begin
      if (act_set[i]) begin
        if (i >= int'(lim)) begin
          close_err = 1'b1;
        end else if (tab_a[i] == nfa_pkg::NO_SUCC) begin
          exit_seen = 1'b1;
        end else if (tab_sym[i] == nfa_pkg::SPLIT_SYMBOL) begin
          if (nfa_pkg::succ_bad(tab_a[i], lim)) begin
            close_err = 1'b1;
          end else begin
            adds = adds | (NSTATES'(1) << tab_a[i][4:0]);
          end
          if (tab_b[i] != nfa_pkg::NO_SUCC) begin
            if (nfa_pkg::succ_bad(tab_b[i], lim)) begin
              close_err = 1'b1;
            end else begin
              adds = adds | (NSTATES'(1) << tab_b[i][4:0]);
            end
          end
        end else if (cur_char != nfa_pkg::NUL_CHAR && tab_sym[i] == cur_char) begin
          if (nfa_pkg::succ_bad(tab_a[i], lim)) begin
            step_err = 1'b1;
          end else begin
            step_set = step_set | (NSTATES'(1) << tab_a[i][4:0]);
          end
        end
      end
    end
  end

  // Settle decision
  assign changed   = |(adds & ~act_set);
  assign matched   = !close_err && exit_seen && (!whole_match || cur_char == nfa_pkg::NUL_CHAR);
  assign any_err   = close_err || step_err;
  assign need_res  = matched || any_err || (step_set == '0);
  assign slot_free = !res_valid || res_pop;
  assign finishing = (state == ST_CLOSE) && !changed && (slot_free || !need_res);

  assign status.closing = (state == ST_CLOSE);
  assign status.settle  = (state == ST_CLOSE) && !changed;

  // Result payload
  always_ff @(posedge clk) begin
    if (finishing && need_res) begin
      if (matched) begin
        res_outcome <= nfa_pkg::OUT_MATCH;
        res_end     <= position;
      end else if (any_err) begin
        res_outcome <= nfa_pkg::OUT_ERROR;
        res_end     <= origin_index;
      end else begin
        res_outcome <= nfa_pkg::OUT_NOMATCH;
        res_end     <= origin_index;
      end
    end
    if (take && head.op == nfa_pkg::OP_CHAR) begin
      cur_char <= head.character;
    end
  end

  // Control state, configuration and active set
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      in_progress  <= 1'b0;
      act_set      <= '0;
      position     <= '0;
      origin_index <= '0;
      res_valid    <= 1'b0;
      whole_match  <= 1'b0;
      state_count  <= nfa_pkg::COUNT_RESET;
    end else begin
      // a new result in the same cycle as a pop keeps the slot full
      if (res_pop && !(finishing && need_res)) begin
        res_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          nfa_pkg::REG_WHOLE_MATCH: whole_match <= cfg_data[0];
          nfa_pkg::REG_STATE_COUNT: state_count <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            unique case (head.op)
              nfa_pkg::OP_START: begin
                act_set      <= NSTATES'(1);
                position     <= head.start_index;
                origin_index <= head.start_index;
                in_progress  <= 1'b1;
              end
              nfa_pkg::OP_CHAR: begin
                if (in_progress) begin
                  state <= ST_CLOSE;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CLOSE: begin
          if (changed) begin
            act_set <= act_set | adds;
          end else if (finishing) begin
            state <= ST_IDLE;
            if (need_res) begin
              res_valid   <= 1'b1;
              in_progress <= 1'b0;
              if (!matched && !any_err) begin
                act_set <= '0;
              end
            end else begin
              act_set  <= step_set;
              position <= position + 16'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
